/* hdl/ptsqd_pkg.sv */
// Shared types and constants for the point-to-triangle squared distance block.
// No dependencies; compiled first.
package ptsqd_pkg;

   localparam int DIST_WIDTH   = 36;
   localparam int REGION_WIDTH = 3;

   // Regions of the (s,t) parameter plane.
   typedef enum logic [REGION_WIDTH-1:0] {
      REGION_INTERIOR = 3'd0,
      REGION_HYP      = 3'd1,
      REGION_HYP_T    = 3'd2,
      REGION_S_ZERO   = 3'd3,
      REGION_CORNER   = 3'd4,
      REGION_T_ZERO   = 3'd5,
      REGION_HYP_S    = 3'd6
   } region_type;

   // How the minimum is formed: at a vertex, on an edge, or inside the triangle.
   typedef enum logic [1:0] {
      KIND_POINT    = 2'd0,
      KIND_EDGE     = 2'd1,
      KIND_INTERIOR = 2'd2
   } kind_type;

   // Narrow compare results formed one stage ahead of the classification.
   typedef struct packed {
      logic d_neg;
      logic e_neg;
      logic ad_le0;
      logic ce_le0;
      logic n2_pos;
      logic n2_ge_den;
      logic n6_pos;
      logic n6_ge_den;
   } cmp_flags_type;

endpackage

/* hdl/ptsqd_if.sv */
// Valid/ready channel interfaces for the point-triangle distance block.
// Depends on ptsqd_pkg for the result field widths.
interface ptsqd_req_if #(parameter int CW = 16) ();
   logic valid;
   logic ready;
   logic signed [CW-1:0] v0_x, v0_y, v0_z;
   logic signed [CW-1:0] v1_x, v1_y, v1_z;
   logic signed [CW-1:0] v2_x, v2_y, v2_z;
   logic signed [CW-1:0] query_x, query_y, query_z;

   modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                   v2_x, v2_y, v2_z, query_x, query_y, query_z, input ready);
   modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                 v2_x, v2_y, v2_z, query_x, query_y, query_z, output ready);
endinterface

interface ptsqd_rsp_if ();
   logic valid;
   logic ready;
   logic [ptsqd_pkg::DIST_WIDTH-1:0]   sq_distance;
   logic [ptsqd_pkg::REGION_WIDTH-1:0] region;
   logic                               degenerate;

   modport source (output valid, sq_distance, region, degenerate, input ready);
   modport sink (input valid, sq_distance, region, degenerate, output ready);
endinterface

/* hdl/point_triangle_sq_distance_top.sv */
// An accepted request beat passes nine arithmetic stages, one stage per quotient
// bit of the rounding divider, and the output register on its way to the response.
// Throughput: one beat per cycle while the response is taken; every stage moves on
// its own, so bubbles close up under a stalled output. Reset (synchronous) clears
// only the stage valid bits.
// Depends on ptsqd_pkg and ptsqd_if.
module point_triangle_sq_distance_top #(
   parameter int COORD_WIDTH = 16
) (
   input logic         clock,
   input logic         reset,
   ptsqd_req_if.sink   req_ch,
   ptsqd_rsp_if.source rsp_ch
);
   import ptsqd_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int EW   = CW + 1;          // edge components
   localparam int PW   = 2 * EW;          // component products
   localparam int DW   = PW + 2;          // dot products a..f
   localparam int VW   = DW + 2;          // vertex values, denominators, numerators
   localparam int XW   = 2 * DW + 1;      // det, s, t
   localparam int LO   = DW + 1;          // low slice of det, s, t
   localparam int PLW  = 2 * DW + 2;      // sliced products
   localparam int EPW  = 2 * VW;          // edge products
   localparam int NW   = 3 * DW + 3;      // distance numerator
   localparam int QW   = DIST_WIDTH;
   localparam int RW   = XW + 1;          // divider remainder and divisor
   localparam int N2A  = NW + 1;
   localparam int N2B  = QW + RW;
   localparam int N2W  = (N2A > N2B) ? N2A : N2B;
   localparam int DV0  = 9;
   localparam int SOUT = DV0 + QW;
   localparam int NS   = SOUT + 1;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_ch.ready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_ch.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_ch.valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Stage 1: edge vectors and offset.
   logic signed [CW-1:0] v0 [3];
   logic signed [CW-1:0] v1 [3];
   logic signed [CW-1:0] v2 [3];
   logic signed [CW-1:0] qp [3];
   logic signed [EW-1:0] s1_e0_in [3], s1_e0_ff [3];
   logic signed [EW-1:0] s1_e1_in [3], s1_e1_ff [3];
   logic signed [EW-1:0] s1_dv_in [3], s1_dv_ff [3];

   always_comb begin
      v0[0] = req_ch.v0_x;    v0[1] = req_ch.v0_y;    v0[2] = req_ch.v0_z;
      v1[0] = req_ch.v1_x;    v1[1] = req_ch.v1_y;    v1[2] = req_ch.v1_z;
      v2[0] = req_ch.v2_x;    v2[1] = req_ch.v2_y;    v2[2] = req_ch.v2_z;
      qp[0] = req_ch.query_x; qp[1] = req_ch.query_y; qp[2] = req_ch.query_z;
      for (int i = 0; i < 3; i++) begin
         s1_e0_in[i] = EW'(v1[i]) - EW'(v0[i]);
         s1_e1_in[i] = EW'(v2[i]) - EW'(v0[i]);
         s1_dv_in[i] = EW'(v0[i]) - EW'(qp[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_e0_ff <= s1_e0_in;
         s1_e1_ff <= s1_e1_in;
         s1_dv_ff <= s1_dv_in;
      end
   end

   // Stage 2: component products.
   logic signed [PW-1:0] s2_pa_in [3], s2_pa_ff [3];
   logic signed [PW-1:0] s2_pb_in [3], s2_pb_ff [3];
   logic signed [PW-1:0] s2_pc_in [3], s2_pc_ff [3];
   logic signed [PW-1:0] s2_pd_in [3], s2_pd_ff [3];
   logic signed [PW-1:0] s2_pe_in [3], s2_pe_ff [3];
   logic signed [PW-1:0] s2_pf_in [3], s2_pf_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_pa_in[i] = PW'(s1_e0_ff[i]) * PW'(s1_e0_ff[i]);
         s2_pb_in[i] = PW'(s1_e0_ff[i]) * PW'(s1_e1_ff[i]);
         s2_pc_in[i] = PW'(s1_e1_ff[i]) * PW'(s1_e1_ff[i]);
         s2_pd_in[i] = PW'(s1_e0_ff[i]) * PW'(s1_dv_ff[i]);
         s2_pe_in[i] = PW'(s1_e1_ff[i]) * PW'(s1_dv_ff[i]);
         s2_pf_in[i] = PW'(s1_dv_ff[i]) * PW'(s1_dv_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_pa_ff <= s2_pa_in;
         s2_pb_ff <= s2_pb_in;
         s2_pc_ff <= s2_pc_in;
         s2_pd_ff <= s2_pd_in;
         s2_pe_ff <= s2_pe_in;
         s2_pf_ff <= s2_pf_in;
      end
   end

   // Stage 3: dot products.
   logic signed [DW-1:0] s3_a_in, s3_b_in, s3_c_in, s3_d_in, s3_e_in, s3_f_in;
   logic signed [DW-1:0] s3_a_ff, s3_b_ff, s3_c_ff, s3_d_ff, s3_e_ff, s3_f_ff;

   assign s3_a_in = DW'(s2_pa_ff[0]) + DW'(s2_pa_ff[1]) + DW'(s2_pa_ff[2]);
   assign s3_b_in = DW'(s2_pb_ff[0]) + DW'(s2_pb_ff[1]) + DW'(s2_pb_ff[2]);
   assign s3_c_in = DW'(s2_pc_ff[0]) + DW'(s2_pc_ff[1]) + DW'(s2_pc_ff[2]);
   assign s3_d_in = DW'(s2_pd_ff[0]) + DW'(s2_pd_ff[1]) + DW'(s2_pd_ff[2]);
   assign s3_e_in = DW'(s2_pe_ff[0]) + DW'(s2_pe_ff[1]) + DW'(s2_pe_ff[2]);
   assign s3_f_in = DW'(s2_pf_ff[0]) + DW'(s2_pf_ff[1]) + DW'(s2_pf_ff[2]);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_a_ff <= s3_a_in;
         s3_b_ff <= s3_b_in;
         s3_c_ff <= s3_c_in;
         s3_d_ff <= s3_d_in;
         s3_e_ff <= s3_e_in;
         s3_f_ff <= s3_f_in;
      end
   end

   // Stage 4: products for det, s, t and the narrow sums used by the edge cases.
   logic signed [XW-1:0] s4_ac_in, s4_bb_in, s4_be_in, s4_cd_in, s4_bd_in, s4_ae_in;
   logic signed [XW-1:0] s4_ac_ff, s4_bb_ff, s4_be_ff, s4_cd_ff, s4_bd_ff, s4_ae_ff;
   logic signed [VW-1:0] s4_vtx1_in, s4_vtx2_in, s4_denom_in, s4_n2_in, s4_n6_in;
   logic signed [VW-1:0] s4_vtx1_ff, s4_vtx2_ff, s4_denom_ff, s4_n2_ff, s4_n6_ff;
   logic signed [VW-1:0] s4_ce_in, s4_ad_in, s4_ce_ff, s4_ad_ff;
   logic signed [DW-1:0] s4_a_ff, s4_c_ff, s4_d_ff, s4_e_ff, s4_f_ff;

   always_comb begin
      s4_ac_in    = XW'(s3_a_ff) * XW'(s3_c_ff);
      s4_bb_in    = XW'(s3_b_ff) * XW'(s3_b_ff);
      s4_be_in    = XW'(s3_b_ff) * XW'(s3_e_ff);
      s4_cd_in    = XW'(s3_c_ff) * XW'(s3_d_ff);
      s4_bd_in    = XW'(s3_b_ff) * XW'(s3_d_ff);
      s4_ae_in    = XW'(s3_a_ff) * XW'(s3_e_ff);
      s4_vtx1_in  = VW'(s3_a_ff) + (VW'(s3_d_ff) <<< 1) + VW'(s3_f_ff);
      s4_vtx2_in  = VW'(s3_c_ff) + (VW'(s3_e_ff) <<< 1) + VW'(s3_f_ff);
      s4_denom_in = VW'(s3_a_ff) - (VW'(s3_b_ff) <<< 1) + VW'(s3_c_ff);
      s4_ce_in    = VW'(s3_c_ff) + VW'(s3_e_ff);
      s4_ad_in    = VW'(s3_a_ff) + VW'(s3_d_ff);
      s4_n2_in    = VW'(s3_c_ff) + VW'(s3_e_ff) - VW'(s3_b_ff) - VW'(s3_d_ff);
      s4_n6_in    = VW'(s3_a_ff) + VW'(s3_d_ff) - VW'(s3_b_ff) - VW'(s3_e_ff);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_ac_ff    <= s4_ac_in;
         s4_bb_ff    <= s4_bb_in;
         s4_be_ff    <= s4_be_in;
         s4_cd_ff    <= s4_cd_in;
         s4_bd_ff    <= s4_bd_in;
         s4_ae_ff    <= s4_ae_in;
         s4_vtx1_ff  <= s4_vtx1_in;
         s4_vtx2_ff  <= s4_vtx2_in;
         s4_denom_ff <= s4_denom_in;
         s4_ce_ff    <= s4_ce_in;
         s4_ad_ff    <= s4_ad_in;
         s4_n2_ff    <= s4_n2_in;
         s4_n6_ff    <= s4_n6_in;
         s4_a_ff     <= s3_a_ff;
         s4_c_ff     <= s3_c_ff;
         s4_d_ff     <= s3_d_ff;
         s4_e_ff     <= s3_e_ff;
         s4_f_ff     <= s3_f_ff;
      end
   end

   // Stage 5: det, s, t and the compare flags of the edge cases.
   logic signed [XW-1:0] s5_det_in, s5_s_in, s5_t_in, s5_det_ff, s5_s_ff, s5_t_ff;
   cmp_flags_type        s5_flags_in, s5_flags_ff;
   logic signed [VW-1:0] s5_vtx1_ff, s5_vtx2_ff, s5_denom_ff, s5_n2_ff, s5_n6_ff;
   logic signed [DW-1:0] s5_a_ff, s5_c_ff, s5_d_ff, s5_e_ff, s5_f_ff;

   always_comb begin
      s5_det_in             = s4_ac_ff - s4_bb_ff;
      s5_s_in               = s4_be_ff - s4_cd_ff;
      s5_t_in               = s4_bd_ff - s4_ae_ff;
      s5_flags_in.d_neg     = s4_d_ff[DW-1];
      s5_flags_in.e_neg     = s4_e_ff[DW-1];
      s5_flags_in.ad_le0    = (s4_ad_ff <= 0);
      s5_flags_in.ce_le0    = (s4_ce_ff <= 0);
      s5_flags_in.n2_pos    = (s4_n2_ff > 0);
      s5_flags_in.n2_ge_den = (s4_n2_ff >= s4_denom_ff);
      s5_flags_in.n6_pos    = (s4_n6_ff > 0);
      s5_flags_in.n6_ge_den = (s4_n6_ff >= s4_denom_ff);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_det_ff   <= s5_det_in;
         s5_s_ff     <= s5_s_in;
         s5_t_ff     <= s5_t_in;
         s5_flags_ff <= s5_flags_in;
         s5_vtx1_ff  <= s4_vtx1_ff;
         s5_vtx2_ff  <= s4_vtx2_ff;
         s5_denom_ff <= s4_denom_ff;
         s5_n2_ff    <= s4_n2_ff;
         s5_n6_ff    <= s4_n6_ff;
         s5_a_ff     <= s4_a_ff;
         s5_c_ff     <= s4_c_ff;
         s5_d_ff     <= s4_d_ff;
         s5_e_ff     <= s4_e_ff;
         s5_f_ff     <= s4_f_ff;
      end
   end

   // Stage 6: region classification and choice of vertex, edge or interior.
   kind_type             s6_kind_in, s6_kind_ff;
   region_type           s6_region_in, s6_region_ff;
   logic                 s6_degen_in, s6_degen_ff;
   logic signed [VW-1:0] s6_base_in, s6_ex_in, s6_ey_in, s6_base_ff, s6_ex_ff, s6_ey_ff;
   logic signed [XW-1:0] s6_det_ff, s6_s_ff, s6_t_ff;
   logic signed [DW-1:0] s6_d_ff, s6_e_ff, s6_f_ff;
   logic signed [VW-1:0] f_v, a_v, c_v, d_v, e_v;
   logic                 det_zero, inner, s_neg, t_neg;

   always_comb begin
      f_v      = VW'(s5_f_ff);
      a_v      = VW'(s5_a_ff);
      c_v      = VW'(s5_c_ff);
      d_v      = VW'(s5_d_ff);
      e_v      = VW'(s5_e_ff);
      det_zero = (s5_det_ff == '0);
      inner    = ((XW+1)'(s5_s_ff) + (XW+1)'(s5_t_ff)) <= (XW+1)'(s5_det_ff);
      s_neg    = s5_s_ff[XW-1];
      t_neg    = s5_t_ff[XW-1];

      s6_kind_in   = KIND_POINT;
      s6_region_in = REGION_INTERIOR;
      s6_degen_in  = 1'b0;
      s6_base_in   = f_v;
      s6_ex_in     = d_v;
      s6_ey_in     = a_v;

      if (det_zero) begin
         s6_degen_in = 1'b1;
      end else if (inner) begin
         if (s_neg && t_neg && s5_flags_ff.d_neg) begin
            s6_region_in = REGION_CORNER;
            if (s5_flags_ff.ad_le0) begin
               s6_base_in = s5_vtx1_ff;
            end else begin
               s6_kind_in = KIND_EDGE;
            end
         end else if (s_neg) begin
            // The corner region with d not negative falls back on the s = 0 edge.
            s6_region_in = t_neg ? REGION_CORNER : REGION_S_ZERO;
            if (!s5_flags_ff.e_neg) begin
               s6_base_in = f_v;
            end else if (s5_flags_ff.ce_le0) begin
               s6_base_in = s5_vtx2_ff;
            end else begin
               s6_kind_in = KIND_EDGE;
               s6_ex_in   = e_v;
               s6_ey_in   = c_v;
            end
         end else if (t_neg) begin
            s6_region_in = REGION_T_ZERO;
            if (!s5_flags_ff.d_neg) begin
               s6_base_in = f_v;
            end else if (s5_flags_ff.ad_le0) begin
               s6_base_in = s5_vtx1_ff;
            end else begin
               s6_kind_in = KIND_EDGE;
            end
         end else begin
            s6_kind_in = KIND_INTERIOR;
         end
      end else begin
         if (s_neg) begin
            s6_region_in = REGION_HYP_T;
            if (s5_flags_ff.n2_pos) begin
               if (s5_flags_ff.n2_ge_den) begin
                  s6_base_in = s5_vtx1_ff;
               end else begin
                  s6_kind_in = KIND_EDGE;
                  s6_base_in = s5_vtx2_ff;
                  s6_ex_in   = s5_n2_ff;
                  s6_ey_in   = s5_denom_ff;
               end
            end else if (s5_flags_ff.ce_le0) begin
               s6_base_in = s5_vtx2_ff;
            end else if (!s5_flags_ff.e_neg) begin
               s6_base_in = f_v;
            end else begin
               s6_kind_in = KIND_EDGE;
               s6_ex_in   = e_v;
               s6_ey_in   = c_v;
            end
         end else if (t_neg) begin
            s6_region_in = REGION_HYP_S;
            if (s5_flags_ff.n6_pos) begin
               if (s5_flags_ff.n6_ge_den) begin
                  s6_base_in = s5_vtx2_ff;
               end else begin
                  s6_kind_in = KIND_EDGE;
                  s6_base_in = s5_vtx1_ff;
                  s6_ex_in   = s5_n6_ff;
                  s6_ey_in   = s5_denom_ff;
               end
            end else if (s5_flags_ff.ad_le0) begin
               s6_base_in = s5_vtx1_ff;
            end else if (!s5_flags_ff.d_neg) begin
               s6_base_in = f_v;
            end else begin
               s6_kind_in = KIND_EDGE;
            end
         end else begin
            s6_region_in = REGION_HYP;
            if (!s5_flags_ff.n2_pos) begin
               s6_base_in = s5_vtx2_ff;
            end else if (s5_flags_ff.n2_ge_den) begin
               s6_base_in = s5_vtx1_ff;
            end else begin
               s6_kind_in = KIND_EDGE;
               s6_base_in = s5_vtx2_ff;
               s6_ex_in   = s5_n2_ff;
               s6_ey_in   = s5_denom_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_kind_ff   <= s6_kind_in;
         s6_region_ff <= s6_region_in;
         s6_degen_ff  <= s6_degen_in;
         s6_base_ff   <= s6_base_in;
         s6_ex_ff     <= s6_ex_in;
         s6_ey_ff     <= s6_ey_in;
         s6_det_ff    <= s5_det_ff;
         s6_s_ff      <= s5_s_ff;
         s6_t_ff      <= s5_t_ff;
         s6_d_ff      <= s5_d_ff;
         s6_e_ff      <= s5_e_ff;
         s6_f_ff      <= s5_f_ff;
      end
   end

   // Stage 7: edge products, and the interior products with det, s, t cut in two.
   logic signed [EPW-1:0] s7_by_in, s7_xx_in, s7_by_ff, s7_xx_ff;
   logic signed [PLW-1:0] s7_lo_in [3], s7_hi_in [3], s7_lo_ff [3], s7_hi_ff [3];
   logic signed [DW-1:0]  mx [3];
   logic signed [XW-1:0]  my [3];
   kind_type              s7_kind_ff;
   region_type            s7_region_ff;
   logic                  s7_degen_ff;
   logic signed [VW-1:0]  s7_base_ff, s7_ey_ff;
   logic signed [XW-1:0]  s7_det_ff;

   always_comb begin
      s7_by_in = EPW'(s6_base_ff) * EPW'(s6_ey_ff);
      s7_xx_in = EPW'(s6_ex_ff) * EPW'(s6_ex_ff);
      mx[0] = s6_f_ff;  my[0] = s6_det_ff;
      mx[1] = s6_d_ff;  my[1] = s6_s_ff;
      mx[2] = s6_e_ff;  my[2] = s6_t_ff;
      for (int i = 0; i < 3; i++) begin
         s7_lo_in[i] = PLW'(mx[i]) * PLW'($signed({1'b0, my[i][LO-1:0]}));
         s7_hi_in[i] = PLW'(mx[i]) * PLW'($signed(my[i][XW-1:LO]));
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_by_ff     <= s7_by_in;
         s7_xx_ff     <= s7_xx_in;
         s7_lo_ff     <= s7_lo_in;
         s7_hi_ff     <= s7_hi_in;
         s7_kind_ff   <= s6_kind_ff;
         s7_region_ff <= s6_region_ff;
         s7_degen_ff  <= s6_degen_ff;
         s7_base_ff   <= s6_base_ff;
         s7_ey_ff     <= s6_ey_ff;
         s7_det_ff    <= s6_det_ff;
      end
   end

   // Stage 8: numerator and denominator of the distance.
   logic signed [NW-1:0] s8_num_in, s8_num_ff;
   logic signed [XW-1:0] s8_den_in, s8_den_ff;
   region_type           s8_region_ff;
   logic                 s8_degen_ff;
   logic signed [NW-1:0] interior_num;

   always_comb begin
      interior_num = '0;
      for (int i = 0; i < 3; i++) begin
         interior_num = interior_num + (NW'(s7_hi_ff[i]) <<< LO) + NW'(s7_lo_ff[i]);
      end
      case (s7_kind_ff)
         KIND_INTERIOR: begin
            s8_num_in = interior_num;
            s8_den_in = s7_det_ff;
         end
         KIND_EDGE: begin
            s8_num_in = NW'(s7_by_ff) - NW'(s7_xx_ff);
            s8_den_in = XW'(s7_ey_ff);
         end
         default: begin
            s8_num_in = NW'(s7_base_ff);
            s8_den_in = XW'(1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s8_num_ff    <= s8_num_in;
         s8_den_ff    <= s8_den_in;
         s8_region_ff <= s7_region_ff;
         s8_degen_ff  <= s7_degen_ff;
      end
   end

   // Stage 9: rounding offset, zero and saturation checks, divider setup.
   // The quotient floor((2n + d) / 2d) is the distance rounded to nearest.
   logic signed [N2W-1:0] n2;
   logic [RW-1:0]         s9_r_in, s9_r_ff, s9_d_in, s9_d_ff;
   logic [QW-1:0]         s9_n_in, s9_n_ff;
   logic                  s9_zero_in, s9_zero_ff, s9_sat_in, s9_sat_ff;
   region_type            s9_region_ff;
   logic                  s9_degen_ff;

   always_comb begin
      n2         = (N2W'(s8_num_ff) <<< 1) + N2W'(s8_den_ff);
      s9_d_in    = {s8_den_ff, 1'b0};
      s9_zero_in = s8_num_ff[NW-1] || s8_den_ff[XW-1] || (s8_den_ff == '0);
      s9_sat_in  = n2[N2W-1:QW] >= (N2W-QW)'(s9_d_in);
      s9_r_in    = n2[QW +: RW];
      s9_n_in    = n2[QW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s9_r_ff      <= s9_r_in;
         s9_d_ff      <= s9_d_in;
         s9_n_ff      <= s9_n_in;
         s9_zero_ff   <= s9_zero_in;
         s9_sat_ff    <= s9_sat_in;
         s9_region_ff <= s8_region_ff;
         s9_degen_ff  <= s8_degen_ff;
      end
   end

   // Divider: one restoring step per stage, one quotient bit each.
   logic [RW-1:0] dv_r_in [QW], dv_r_ff [QW], dv_d_ff [QW];
   logic [QW-1:0] dv_n_in [QW], dv_n_ff [QW], dv_q_in [QW], dv_q_ff [QW];
   logic          dv_zero_ff [QW], dv_sat_ff [QW], dv_degen_ff [QW];
   region_type    dv_region_ff [QW];
   logic [RW-1:0] src_r [QW], src_d [QW], trial [QW];
   logic [QW-1:0] src_n [QW], src_q [QW];
   logic          src_zero [QW], src_sat [QW], src_degen [QW], take [QW];
   region_type    src_region [QW];

   always_comb begin
      src_r[0]      = s9_r_ff;
      src_d[0]      = s9_d_ff;
      src_n[0]      = s9_n_ff;
      src_q[0]      = '0;
      src_zero[0]   = s9_zero_ff;
      src_sat[0]    = s9_sat_ff;
      src_degen[0]  = s9_degen_ff;
      src_region[0] = s9_region_ff;
      for (int j = 1; j < QW; j++) begin
         src_r[j]      = dv_r_ff[j-1];
         src_d[j]      = dv_d_ff[j-1];
         src_n[j]      = dv_n_ff[j-1];
         src_q[j]      = dv_q_ff[j-1];
         src_zero[j]   = dv_zero_ff[j-1];
         src_sat[j]    = dv_sat_ff[j-1];
         src_degen[j]  = dv_degen_ff[j-1];
         src_region[j] = dv_region_ff[j-1];
      end
      for (int j = 0; j < QW; j++) begin
         trial[j]   = {src_r[j][RW-2:0], src_n[j][QW-1]};
         take[j]    = trial[j] >= src_d[j];
         dv_r_in[j] = take[j] ? (trial[j] - src_d[j]) : trial[j];
         dv_n_in[j] = src_n[j] << 1;
         dv_q_in[j] = {src_q[j][QW-2:0], take[j]};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < QW; j++) begin
         if (en[DV0+j]) begin
            dv_r_ff[j]      <= dv_r_in[j];
            dv_d_ff[j]      <= src_d[j];
            dv_n_ff[j]      <= dv_n_in[j];
            dv_q_ff[j]      <= dv_q_in[j];
            dv_zero_ff[j]   <= src_zero[j];
            dv_sat_ff[j]    <= src_sat[j];
            dv_degen_ff[j]  <= src_degen[j];
            dv_region_ff[j] <= src_region[j];
         end
      end
   end

   // Output register.
   logic [QW-1:0] out_dist_in, out_dist_ff;
   region_type    out_region_ff;
   logic          out_degen_ff;

   always_comb begin
      if (dv_zero_ff[QW-1]) begin
         out_dist_in = '0;
      end else if (dv_sat_ff[QW-1]) begin
         out_dist_in = '1;
      end else begin
         out_dist_in = dv_q_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[SOUT]) begin
         out_dist_ff   <= out_dist_in;
         out_region_ff <= dv_region_ff[QW-1];
         out_degen_ff  <= dv_degen_ff[QW-1];
      end
   end

   assign rsp_ch.valid       = v_ff[SOUT];
   assign rsp_ch.sq_distance = out_dist_ff;
   assign rsp_ch.region      = out_region_ff;
   assign rsp_ch.degenerate  = out_degen_ff;

   // A degenerate triangle always reports the interior region code.
   a_degen_region: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.degenerate |-> rsp_ch.region == REGION_INTERIOR)
      else $error("degenerate beat with nonzero region");

   // Reset empties every stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> v_ff == '0)
      else $error("pipeline not empty after reset");

   // An accepted request beat occupies the first stage on the next cycle.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> v_ff[0])
      else $error("accepted beat lost at first stage");

   // A held response is never overwritten by the stage behind it.
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      v_ff[SOUT] && !rsp_ch.ready |=> v_ff[SOUT] && $stable(out_dist_ff))
      else $error("stalled response overwritten");

endmodule
